@@ hdl/sps_pkg.sv @@
// Package of the sorter program sequencer: item, state and result types,
// program, phase, action and command codes, and port widths.
// Depends on nothing; every other file of the block refers to it by scoped names.
package sps_pkg;

  // Port widths: tdata is padded with zeros to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  // Actions, carried in the input tuser.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_INIT  = 2'd3;

  // Programs.
  localparam logic [2:0] PRG_REST    = 3'd0;
  localparam logic [2:0] PRG_STEPPER = 3'd1;
  localparam logic [2:0] PRG_SERVO   = 3'd2;
  localparam logic [2:0] PRG_SENSOR  = 3'd3;
  localparam logic [2:0] PRG_SINGLE  = 3'd4;
  localparam logic [2:0] PRG_AUTO    = 3'd5;
  localparam logic [2:0] PRG_CYCLE   = 3'd6;
  localparam logic [2:0] PRG_STARTUP = 3'd7;

  // Steps inside a program.
  localparam logic [2:0] STEP_IDLE  = 3'd0;
  localparam logic [2:0] STEP_BEGIN = 3'd1;
  localparam logic [2:0] STEP_2     = 3'd2;
  localparam logic [2:0] STEP_3     = 3'd3;
  localparam logic [2:0] STEP_4     = 3'd4;
  localparam logic [2:0] STEP_5     = 3'd5;
  localparam logic [2:0] STEP_6     = 3'd6;

  // Phases of the sorting cycle.
  localparam logic [1:0] PH_SERVO  = 2'd0;
  localparam logic [1:0] PH_DISC   = 2'd1;
  localparam logic [1:0] PH_COLOUR = 2'd2;

  // LED and switched output commands.
  localparam logic [1:0] LED_NONE  = 2'd0;
  localparam logic [1:0] LED_GREEN = 2'd1;
  localparam logic [1:0] LED_OFF   = 2'd2;
  localparam logic [1:0] AUX_NONE  = 2'd0;
  localparam logic [1:0] AUX_ON    = 2'd1;
  localparam logic [1:0] AUX_OFF   = 2'd2;

  // Display messages.
  localparam logic [3:0] MSG_NONE      = 4'd0;
  localparam logic [3:0] MSG_STOPPING  = 4'd1;
  localparam logic [3:0] MSG_DISC      = 4'd2;
  localparam logic [3:0] MSG_SERVO     = 4'd3;
  localparam logic [3:0] MSG_DETECTING = 4'd4;
  localparam logic [3:0] MSG_SORTING   = 4'd5;
  localparam logic [3:0] MSG_CYCLING   = 4'd6;
  localparam logic [3:0] MSG_SPLASH    = 4'd7;
  localparam logic [3:0] MSG_WELCOME   = 4'd8;
  localparam logic [3:0] MSG_COLOUR    = 4'd9;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLASH_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_END = 2'd2;
  localparam logic [15:0] ACTION_WAIT_RST = 16'd1000;
  localparam logic [15:0] SPLASH_WAIT_RST = 16'd3000;
  localparam logic [15:0] STARTUP_END_RST = 16'd6000;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  program_request;
    logic [31:0] now_ms;
    logic        stepper_busy;
    logic        sensor_busy;
    logic        led_rested;
    logic [3:0]  colour_in;
  } item_t;

  typedef struct packed {
    logic [15:0] action_wait_ms;
    logic [15:0] splash_wait_ms;
    logic [15:0] startup_end_ms;
  } cfg_t;

  typedef struct packed {
    logic        ready;
    logic        lock_flag;
    logic        stop_pending;
    logic [1:0]  previous_phase;
    logic [2:0]  active_program;
    logic [2:0]  step_index;
    logic [31:0] program_start_ms;
    logic [3:0]  colour_store;
  } state_t;

  typedef struct packed {
    logic       is_busy;
    logic [2:0] program_now;
    logic       is_locked;
    logic       disc_step_cmd;
    logic       disc_cycle_cmd;
    logic       disc_halt_cmd;
    logic       colour_request_cmd;
    logic       servo_move_cmd;
    logic [3:0] held_colour;
    logic [1:0] led_cmd;
    logic [1:0] aux_output_cmd;
    logic [3:0] display_msg;
  } result_t;

endpackage

@@ hdl/sps_in_reg.sv @@
// Input register of the sorter program sequencer: takes one transfer and
// unpacks it into an item. Depends on sps_pkg.
module sps_in_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sps_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            take,
  output logic                            item_valid,
  output sps_pkg::item_t                  item
);

  logic           valid_r;
  logic           valid_nxt;
  sps_pkg::item_t item_r;

  // The slot is free when empty or when its item moves on this cycle.
  assign in_tready  = !valid_r || take;
  assign valid_nxt  = (in_tvalid && in_tready) || (valid_r && !take);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action          <= in_tuser;
      item_r.program_request <= in_tdata[2:0];
      item_r.now_ms          <= in_tdata[34:3];
      item_r.stepper_busy    <= in_tdata[35];
      item_r.sensor_busy     <= in_tdata[36];
      item_r.led_rested      <= in_tdata[37];
      item_r.colour_in       <= in_tdata[41:38];
    end
  end

endmodule

@@ hdl/sps_step.sv @@
// Step logic of the sorter program sequencer: from the current state, the
// configuration and one item, the next state and the result. Depends on sps_pkg.
module sps_step (
  input  sps_pkg::state_t  st,
  input  sps_pkg::cfg_t    cfg,
  input  sps_pkg::item_t   item,
  output sps_pkg::state_t  st_nxt,
  output sps_pkg::result_t res
);

  logic [31:0] elapsed;
  logic [15:0] limit;
  logic        waited;
  logic        stp_busy;
  logic        sns_busy;

  assign stp_busy = item.stepper_busy;
  assign sns_busy = item.sensor_busy;

  // One wrap-safe compare serves every wait; the program picks the limit.
  always_comb begin
    if (st.active_program == sps_pkg::PRG_STARTUP) begin
      limit = (st.step_index == sps_pkg::STEP_3) ? cfg.splash_wait_ms : cfg.startup_end_ms;
    end else begin
      limit = cfg.action_wait_ms;
    end
  end

  assign elapsed = item.now_ms - st.program_start_ms;
  assign waited  = elapsed >= {16'd0, limit};

  always_comb begin
    st_nxt                 = st;
    res.disc_step_cmd      = 1'b0;
    res.disc_cycle_cmd     = 1'b0;
    res.disc_halt_cmd      = 1'b0;
    res.colour_request_cmd = 1'b0;
    res.servo_move_cmd     = 1'b0;
    res.led_cmd            = sps_pkg::LED_NONE;
    res.aux_output_cmd     = sps_pkg::AUX_NONE;
    res.display_msg        = sps_pkg::MSG_NONE;

    case (item.action)
      sps_pkg::ACT_INIT: begin
        st_nxt.ready = 1'b1;
      end
      sps_pkg::ACT_START: begin
        if (st.ready && st.active_program == sps_pkg::PRG_REST) begin
          st_nxt.active_program = item.program_request;
          st_nxt.step_index     = sps_pkg::STEP_BEGIN;
        end
      end
      sps_pkg::ACT_STOP: begin
        if (st.ready && st.active_program != sps_pkg::PRG_REST && !st.lock_flag) begin
          st_nxt.stop_pending = 1'b1;
          res.display_msg     = sps_pkg::MSG_STOPPING;
        end
      end
      default: begin
        if (st.ready && st.active_program != sps_pkg::PRG_REST) begin
          if (st.step_index == sps_pkg::STEP_BEGIN) begin
            // Every program starts by taking the time; all but the automatic
            // and cycling programs lock out stop requests.
            st_nxt.lock_flag        = !(st.active_program == sps_pkg::PRG_AUTO ||
                                        st.active_program == sps_pkg::PRG_CYCLE);
            st_nxt.program_start_ms = item.now_ms;
            st_nxt.step_index       = sps_pkg::STEP_2;
            if (st.active_program == sps_pkg::PRG_AUTO) begin
              res.aux_output_cmd = sps_pkg::AUX_ON;
            end
          end else begin
            case (st.active_program)
              sps_pkg::PRG_STEPPER: begin
                case (st.step_index)
                  sps_pkg::STEP_2: begin
                    res.display_msg   = sps_pkg::MSG_DISC;
                    st_nxt.step_index = sps_pkg::STEP_3;
                  end
                  sps_pkg::STEP_3: begin
                    if (!stp_busy) begin
                      res.disc_step_cmd = 1'b1;
                      st_nxt.step_index = sps_pkg::STEP_4;
                    end
                  end
                  sps_pkg::STEP_4: begin
                    if (waited) st_nxt.step_index = sps_pkg::STEP_5;
                  end
                  sps_pkg::STEP_5: begin
                    st_nxt.lock_flag      = 1'b0;
                    st_nxt.active_program = sps_pkg::PRG_REST;
                    st_nxt.step_index     = sps_pkg::STEP_IDLE;
                    st_nxt.previous_phase = sps_pkg::PH_SERVO;
                  end
                  default: ;
                endcase
              end
              sps_pkg::PRG_SERVO: begin
                case (st.step_index)
                  sps_pkg::STEP_2: begin
                    res.display_msg   = sps_pkg::MSG_SERVO;
                    st_nxt.step_index = sps_pkg::STEP_3;
                  end
                  sps_pkg::STEP_3: begin
                    res.servo_move_cmd = 1'b1;
                    res.led_cmd        = sps_pkg::LED_GREEN;
                    st_nxt.step_index  = sps_pkg::STEP_4;
                  end
                  sps_pkg::STEP_4: begin
                    if (waited) st_nxt.step_index = sps_pkg::STEP_5;
                  end
                  sps_pkg::STEP_5: begin
                    st_nxt.lock_flag      = 1'b0;
                    res.led_cmd           = sps_pkg::LED_OFF;
                    st_nxt.active_program = sps_pkg::PRG_REST;
                    st_nxt.step_index     = sps_pkg::STEP_IDLE;
                    st_nxt.previous_phase = sps_pkg::PH_SERVO;
                  end
                  default: ;
                endcase
              end
              sps_pkg::PRG_SENSOR: begin
                case (st.step_index)
                  sps_pkg::STEP_2: begin
                    res.display_msg   = sps_pkg::MSG_DETECTING;
                    st_nxt.step_index = sps_pkg::STEP_3;
                  end
                  sps_pkg::STEP_3: begin
                    if (!sns_busy) begin
                      res.colour_request_cmd = 1'b1;
                      st_nxt.step_index      = sps_pkg::STEP_4;
                    end
                  end
                  sps_pkg::STEP_4: begin
                    if (!sns_busy) begin
                      st_nxt.colour_store = item.colour_in;
                      res.display_msg     = sps_pkg::MSG_COLOUR;
                      st_nxt.step_index   = sps_pkg::STEP_5;
                    end
                  end
                  sps_pkg::STEP_5: begin
                    if (waited) st_nxt.step_index = sps_pkg::STEP_6;
                  end
                  sps_pkg::STEP_6: begin
                    st_nxt.lock_flag      = 1'b0;
                    st_nxt.active_program = sps_pkg::PRG_REST;
                    st_nxt.step_index     = sps_pkg::STEP_IDLE;
                    st_nxt.previous_phase = sps_pkg::PH_COLOUR;
                  end
                  default: ;
                endcase
              end
              sps_pkg::PRG_SINGLE, sps_pkg::PRG_AUTO: begin
                case (st.step_index)
                  sps_pkg::STEP_2: begin
                    if (st.active_program == sps_pkg::PRG_SINGLE) begin
                      case (st.previous_phase)
                        sps_pkg::PH_SERVO:  res.display_msg = sps_pkg::MSG_DISC;
                        sps_pkg::PH_DISC:   res.display_msg = sps_pkg::MSG_DETECTING;
                        sps_pkg::PH_COLOUR: res.display_msg = sps_pkg::MSG_SERVO;
                        default: ;
                      endcase
                    end else if (!st.stop_pending) begin
                      res.display_msg = sps_pkg::MSG_SORTING;
                    end
                    st_nxt.step_index = sps_pkg::STEP_3;
                  end
                  sps_pkg::STEP_3: begin
                    case (st.previous_phase)
                      sps_pkg::PH_SERVO: begin
                        if (!stp_busy) begin
                          res.disc_step_cmd = 1'b1;
                          st_nxt.step_index = sps_pkg::STEP_4;
                        end
                      end
                      sps_pkg::PH_DISC: begin
                        if (!sns_busy) begin
                          res.colour_request_cmd = 1'b1;
                          st_nxt.step_index      = sps_pkg::STEP_4;
                        end
                      end
                      sps_pkg::PH_COLOUR: begin
                        res.servo_move_cmd = 1'b1;
                        res.led_cmd        = sps_pkg::LED_GREEN;
                        st_nxt.step_index  = sps_pkg::STEP_4;
                      end
                      default: ;
                    endcase
                  end
                  sps_pkg::STEP_4: begin
                    case (st.previous_phase)
                      sps_pkg::PH_SERVO: begin
                        if (!stp_busy) st_nxt.step_index = sps_pkg::STEP_5;
                      end
                      sps_pkg::PH_DISC: begin
                        if (!sns_busy) begin
                          st_nxt.colour_store = item.colour_in;
                          st_nxt.step_index   = sps_pkg::STEP_5;
                        end
                      end
                      sps_pkg::PH_COLOUR: begin
                        // The single step waits out its time; the automatic
                        // loop waits for the LED to finish its display.
                        if (st.active_program == sps_pkg::PRG_SINGLE ? waited
                                                                     : item.led_rested) begin
                          st_nxt.step_index = sps_pkg::STEP_5;
                        end
                      end
                      default: ;
                    endcase
                  end
                  sps_pkg::STEP_5: begin
                    case (st.previous_phase)
                      sps_pkg::PH_SERVO:  st_nxt.previous_phase = sps_pkg::PH_DISC;
                      sps_pkg::PH_DISC:   st_nxt.previous_phase = sps_pkg::PH_COLOUR;
                      sps_pkg::PH_COLOUR: begin
                        res.led_cmd           = sps_pkg::LED_OFF;
                        st_nxt.previous_phase = sps_pkg::PH_SERVO;
                      end
                      default: ;
                    endcase
                    if (st.active_program == sps_pkg::PRG_SINGLE) begin
                      st_nxt.lock_flag      = 1'b0;
                      st_nxt.active_program = sps_pkg::PRG_REST;
                      st_nxt.step_index     = sps_pkg::STEP_IDLE;
                    end else if (st.stop_pending) begin
                      st_nxt.active_program = sps_pkg::PRG_REST;
                      st_nxt.step_index     = sps_pkg::STEP_IDLE;
                      res.aux_output_cmd    = sps_pkg::AUX_OFF;
                      st_nxt.stop_pending   = 1'b0;
                    end else begin
                      st_nxt.step_index = sps_pkg::STEP_3;
                    end
                  end
                  default: ;
                endcase
              end
              sps_pkg::PRG_CYCLE: begin
                case (st.step_index)
                  sps_pkg::STEP_2: begin
                    res.display_msg   = sps_pkg::MSG_CYCLING;
                    st_nxt.step_index = sps_pkg::STEP_3;
                  end
                  sps_pkg::STEP_3: begin
                    if (!stp_busy) begin
                      res.disc_cycle_cmd = 1'b1;
                      st_nxt.step_index  = sps_pkg::STEP_4;
                    end
                  end
                  sps_pkg::STEP_4: begin
                    if (waited) st_nxt.step_index = sps_pkg::STEP_5;
                  end
                  sps_pkg::STEP_5: begin
                    if (st.stop_pending) begin
                      res.disc_halt_cmd     = 1'b1;
                      st_nxt.active_program = sps_pkg::PRG_REST;
                      st_nxt.step_index     = sps_pkg::STEP_IDLE;
                      st_nxt.stop_pending   = 1'b0;
                    end
                  end
                  default: ;
                endcase
              end
              sps_pkg::PRG_STARTUP: begin
                case (st.step_index)
                  sps_pkg::STEP_2: begin
                    res.display_msg   = sps_pkg::MSG_SPLASH;
                    st_nxt.step_index = sps_pkg::STEP_3;
                  end
                  sps_pkg::STEP_3: begin
                    if (waited) st_nxt.step_index = sps_pkg::STEP_4;
                  end
                  sps_pkg::STEP_4: begin
                    res.display_msg   = sps_pkg::MSG_WELCOME;
                    st_nxt.step_index = sps_pkg::STEP_5;
                  end
                  sps_pkg::STEP_5: begin
                    if (waited) st_nxt.step_index = sps_pkg::STEP_6;
                  end
                  sps_pkg::STEP_6: begin
                    st_nxt.lock_flag      = 1'b0;
                    st_nxt.active_program = sps_pkg::PRG_REST;
                    st_nxt.step_index     = sps_pkg::STEP_IDLE;
                    st_nxt.previous_phase = sps_pkg::PH_SERVO;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
      end
    endcase

    res.is_busy     = st_nxt.ready && (st_nxt.active_program != sps_pkg::PRG_REST);
    res.program_now = st_nxt.active_program;
    res.is_locked   = st_nxt.lock_flag;
    res.held_colour = st_nxt.colour_store;
  end

endmodule

@@ hdl/sorter_program_sequencer_top.sv @@
// Top level of the sorter program sequencer: configuration registers, program
// state, and the result register. Depends on sps_pkg, sps_in_reg and sps_step.
// Sorter program sequencer. Each input transfer carries one action in
// in_tuser (tick, start program, stop request or initialize) and the time,
// sub-controller status and sensor colour in in_tdata. Every input transfer
// yields exactly one output transfer holding the status after the action and
// the one-transfer command pulses for disc, sensor, servo, LED, switched
// output and display message. The block takes one transfer per clock cycle
// while it is not stalled. A result passes through the input register and
// then the result register; the step logic between them updates the whole
// program state combinationally, using one 32-bit wrap-safe elapsed-time
// subtract and compare. While the result register is full and not taken, the
// input register still holds one more item, and input stalls only when both
// are full. Configuration is written through cfg_we, cfg_index and cfg_wdata:
// index 0 is the action wait, 1 the splash wait and 2 the startup end, all in
// milliseconds; other indexes are ignored. Writes take effect at once and
// belong in idle periods.
module sorter_program_sequencer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata, from bit 0: program_request[2:0], now_ms[34:3], stepper_busy[35],
  // sensor_busy[36], led_rested[37], colour_in[41:38], zeros above.
  input  logic [sps_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: action[1:0].
  input  logic [1:0]                          in_tuser,
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata, from bit 0: is_busy[0], program_now[3:1], is_locked[4],
  // disc_step_cmd[5], disc_cycle_cmd[6], disc_halt_cmd[7],
  // colour_request_cmd[8], servo_move_cmd[9], held_colour[13:10],
  // led_cmd[15:14], aux_output_cmd[17:16], display_msg[21:18], zeros above.
  output logic [sps_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  sps_pkg::cfg_t    cfg_r;
  sps_pkg::state_t  state_r;
  sps_pkg::state_t  state_nxt;
  sps_pkg::result_t res_nxt;
  sps_pkg::result_t res_r;
  sps_pkg::item_t   item;
  logic             item_valid;
  logic             out_valid_r;
  logic             take;

  // An item moves into the result register when that register is empty or
  // its current result is being transferred out in the same cycle.
  assign take = item_valid && (!out_valid_r || out_tready);

  sps_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  sps_step u_step (
    .st     (state_r),
    .cfg    (cfg_r),
    .item   (item),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.action_wait_ms <= sps_pkg::ACTION_WAIT_RST;
      cfg_r.splash_wait_ms <= sps_pkg::SPLASH_WAIT_RST;
      cfg_r.startup_end_ms <= sps_pkg::STARTUP_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sps_pkg::CFG_ACTION_WAIT: cfg_r.action_wait_ms <= cfg_wdata;
        sps_pkg::CFG_SPLASH_WAIT: cfg_r.splash_wait_ms <= cfg_wdata;
        sps_pkg::CFG_STARTUP_END: cfg_r.startup_end_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Program state advances once per item, as the item leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.ready            <= 1'b0;
      state_r.lock_flag        <= 1'b0;
      state_r.stop_pending     <= 1'b0;
      state_r.previous_phase   <= sps_pkg::PH_SERVO;
      state_r.active_program   <= sps_pkg::PRG_STARTUP;
      state_r.step_index       <= sps_pkg::STEP_BEGIN;
      state_r.program_start_ms <= 32'd0;
      state_r.colour_store     <= 4'd0;
    end else if (take) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       res_r.display_msg,
                       res_r.aux_output_cmd,
                       res_r.led_cmd,
                       res_r.held_colour,
                       res_r.servo_move_cmd,
                       res_r.colour_request_cmd,
                       res_r.disc_halt_cmd,
                       res_r.disc_cycle_cmd,
                       res_r.disc_step_cmd,
                       res_r.is_locked,
                       res_r.program_now,
                       res_r.is_busy};

endmodule

@@ tb/sv/tb_sorter_program_sequencer_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of sorter_program_sequencer_top: a scoreboard class predicts each
// result from the accepted transfers, plain tasks drive the input channel and the registers.
// Depends on sps_pkg and the RTL of the sequencer only.
module tb_sorter_program_sequencer_top;

  localparam int IN_W  = sps_pkg::IN_TDATA_W;
  localparam int OUT_W = sps_pkg::OUT_TDATA_W;
  localparam int IDX_W = sps_pkg::CFG_IDX_W;
  // Register index that the block must ignore.
  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
  // Start times of the two directed programs; the first one lies just before the wrap.
  localparam logic [31:0] SPLASH_T0 = 32'hFFFF_FF00;
  localparam logic [31:0] SENSOR_T0 = 32'd5000;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 3000;

  // The scoreboard mirrors the sequencer state, turns every accepted input transfer into
  // the result that the block must return, and checks results in order.
  class sorter_step_tracker_t;
    logic [15:0]      wait_action, wait_splash, wait_end;
    bit               armed, locked, stop_req;
    logic [1:0]       phase;
    logic [2:0]       prog, step;
    logic [31:0]      t_start;
    logic [3:0]       colour;
    sps_pkg::result_t expected_results[$];
    int               mismatches, results_seen;

    function new();
      wait_action = sps_pkg::ACTION_WAIT_RST;
      wait_splash = sps_pkg::SPLASH_WAIT_RST;
      wait_end    = sps_pkg::STARTUP_END_RST;
      armed = 1'b0; locked = 1'b0; stop_req = 1'b0;
      phase = sps_pkg::PH_SERVO; prog = sps_pkg::PRG_STARTUP; step = sps_pkg::STEP_BEGIN;
      t_start = '0; colour = '0;
      mismatches = 0; results_seen = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        sps_pkg::CFG_ACTION_WAIT: wait_action = val;
        sps_pkg::CFG_SPLASH_WAIT: wait_splash = val;
        sps_pkg::CFG_STARTUP_END: wait_end = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Wrap-safe check that the time since the program began has reached a limit.
    function bit elapsed(logic [31:0] now, logic [15:0] lim);
      logic [31:0] d;
      d = now - t_start;
      return d >= {16'd0, lim};
    endfunction

    function void go_idle(logic [1:0] next_phase);
      locked = 1'b0;
      prog = sps_pkg::PRG_REST;
      step = sps_pkg::STEP_IDLE;
      phase = next_phase;
    endfunction

    function void advance(sps_pkg::item_t it, inout sps_pkg::result_t r);
      if (prog == sps_pkg::PRG_REST) return;
      if (step == sps_pkg::STEP_BEGIN) begin
        locked = (prog != sps_pkg::PRG_CYCLE) && (prog != sps_pkg::PRG_AUTO);
        t_start = it.now_ms;
        step = sps_pkg::STEP_2;
        if (prog == sps_pkg::PRG_AUTO) r.aux_output_cmd = sps_pkg::AUX_ON;
        return;
      end
      case (prog)
        sps_pkg::PRG_STEPPER: begin
          case (step)
            sps_pkg::STEP_2: begin
              r.display_msg = sps_pkg::MSG_DISC; step = sps_pkg::STEP_3;
            end
            sps_pkg::STEP_3: if (!it.stepper_busy) begin
              r.disc_step_cmd = 1'b1; step = sps_pkg::STEP_4;
            end
            sps_pkg::STEP_4: if (elapsed(it.now_ms, wait_action)) step = sps_pkg::STEP_5;
            sps_pkg::STEP_5: go_idle(sps_pkg::PH_SERVO);
            default: ;
          endcase
        end
        sps_pkg::PRG_SERVO: begin
          case (step)
            sps_pkg::STEP_2: begin
              r.display_msg = sps_pkg::MSG_SERVO; step = sps_pkg::STEP_3;
            end
            sps_pkg::STEP_3: begin
              r.servo_move_cmd = 1'b1; r.led_cmd = sps_pkg::LED_GREEN; step = sps_pkg::STEP_4;
            end
            sps_pkg::STEP_4: if (elapsed(it.now_ms, wait_action)) step = sps_pkg::STEP_5;
            sps_pkg::STEP_5: begin
              r.led_cmd = sps_pkg::LED_OFF; go_idle(sps_pkg::PH_SERVO);
            end
            default: ;
          endcase
        end
        sps_pkg::PRG_SENSOR: begin
          case (step)
            sps_pkg::STEP_2: begin
              r.display_msg = sps_pkg::MSG_DETECTING; step = sps_pkg::STEP_3;
            end
            sps_pkg::STEP_3: if (!it.sensor_busy) begin
              r.colour_request_cmd = 1'b1; step = sps_pkg::STEP_4;
            end
            sps_pkg::STEP_4: if (!it.sensor_busy) begin
              colour = it.colour_in; r.display_msg = sps_pkg::MSG_COLOUR;
              step = sps_pkg::STEP_5;
            end
            sps_pkg::STEP_5: if (elapsed(it.now_ms, wait_action)) step = sps_pkg::STEP_6;
            sps_pkg::STEP_6: go_idle(sps_pkg::PH_COLOUR);
            default: ;
          endcase
        end
        sps_pkg::PRG_SINGLE, sps_pkg::PRG_AUTO: begin
          case (step)
            sps_pkg::STEP_2: begin
              if (prog == sps_pkg::PRG_SINGLE) begin
                case (phase)
                  sps_pkg::PH_SERVO:  r.display_msg = sps_pkg::MSG_DISC;
                  sps_pkg::PH_DISC:   r.display_msg = sps_pkg::MSG_DETECTING;
                  sps_pkg::PH_COLOUR: r.display_msg = sps_pkg::MSG_SERVO;
                  default: ;
                endcase
              end else if (!stop_req) begin
                r.display_msg = sps_pkg::MSG_SORTING;
              end
              step = sps_pkg::STEP_3;
            end
            sps_pkg::STEP_3: begin
              case (phase)
                sps_pkg::PH_SERVO: if (!it.stepper_busy) begin
                  r.disc_step_cmd = 1'b1; step = sps_pkg::STEP_4;
                end
                sps_pkg::PH_DISC: if (!it.sensor_busy) begin
                  r.colour_request_cmd = 1'b1; step = sps_pkg::STEP_4;
                end
                sps_pkg::PH_COLOUR: begin
                  r.servo_move_cmd = 1'b1; r.led_cmd = sps_pkg::LED_GREEN;
                  step = sps_pkg::STEP_4;
                end
                default: ;
              endcase
            end
            sps_pkg::STEP_4: begin
              case (phase)
                sps_pkg::PH_SERVO: if (!it.stepper_busy) step = sps_pkg::STEP_5;
                sps_pkg::PH_DISC: if (!it.sensor_busy) begin
                  colour = it.colour_in; step = sps_pkg::STEP_5;
                end
                sps_pkg::PH_COLOUR: begin
                  if (prog == sps_pkg::PRG_SINGLE ? elapsed(it.now_ms, wait_action)
                                                  : it.led_rested)
                    step = sps_pkg::STEP_5;
                end
                default: ;
              endcase
            end
            sps_pkg::STEP_5: begin
              case (phase)
                sps_pkg::PH_SERVO:  phase = sps_pkg::PH_DISC;
                sps_pkg::PH_DISC:   phase = sps_pkg::PH_COLOUR;
                sps_pkg::PH_COLOUR: begin
                  r.led_cmd = sps_pkg::LED_OFF; phase = sps_pkg::PH_SERVO;
                end
                default: ;
              endcase
              if (prog == sps_pkg::PRG_SINGLE) begin
                locked = 1'b0; prog = sps_pkg::PRG_REST; step = sps_pkg::STEP_IDLE;
              end else if (stop_req) begin
                prog = sps_pkg::PRG_REST; step = sps_pkg::STEP_IDLE;
                r.aux_output_cmd = sps_pkg::AUX_OFF; stop_req = 1'b0;
              end else begin
                step = sps_pkg::STEP_3;
              end
            end
            default: ;
          endcase
        end
        sps_pkg::PRG_CYCLE: begin
          case (step)
            sps_pkg::STEP_2: begin
              r.display_msg = sps_pkg::MSG_CYCLING; step = sps_pkg::STEP_3;
            end
            sps_pkg::STEP_3: if (!it.stepper_busy) begin
              r.disc_cycle_cmd = 1'b1; step = sps_pkg::STEP_4;
            end
            sps_pkg::STEP_4: if (elapsed(it.now_ms, wait_action)) step = sps_pkg::STEP_5;
            sps_pkg::STEP_5: if (stop_req) begin
              r.disc_halt_cmd = 1'b1; prog = sps_pkg::PRG_REST; step = sps_pkg::STEP_IDLE;
              stop_req = 1'b0;
            end
            default: ;
          endcase
        end
        sps_pkg::PRG_STARTUP: begin
          case (step)
            sps_pkg::STEP_2: begin
              r.display_msg = sps_pkg::MSG_SPLASH; step = sps_pkg::STEP_3;
            end
            sps_pkg::STEP_3: if (elapsed(it.now_ms, wait_splash)) step = sps_pkg::STEP_4;
            sps_pkg::STEP_4: begin
              r.display_msg = sps_pkg::MSG_WELCOME; step = sps_pkg::STEP_5;
            end
            sps_pkg::STEP_5: if (elapsed(it.now_ms, wait_end)) step = sps_pkg::STEP_6;
            sps_pkg::STEP_6: go_idle(sps_pkg::PH_SERVO);
            default: ;
          endcase
        end
        default: ;
      endcase
    endfunction

    function void note_input(sps_pkg::item_t it);
      sps_pkg::result_t r;
      r = '0;
      case (it.action)
        sps_pkg::ACT_INIT: armed = 1'b1;
        sps_pkg::ACT_START: if (armed && prog == sps_pkg::PRG_REST) begin
          prog = it.program_request;
          step = sps_pkg::STEP_BEGIN;
        end
        sps_pkg::ACT_STOP: if (armed && prog != sps_pkg::PRG_REST && !locked) begin
          stop_req = 1'b1;
          r.display_msg = sps_pkg::MSG_STOPPING;
        end
        default: if (armed) advance(it, r);
      endcase
      r.is_busy     = armed && (prog != sps_pkg::PRG_REST);
      r.program_now = prog;
      r.is_locked   = locked;
      r.held_colour = colour;
      expected_results.push_back(r);
    endfunction

    function string diff(string name, logic [3:0] e, logic [3:0] g);
      return (e === g) ? "" : $sformatf(" %s expected %0d actual %0d", name, e, g);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      sps_pkg::result_t e;
      string            bad;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected, tdata %h",
                         results_seen, d));
        return;
      end
      e = expected_results.pop_front();
      bad = {diff("is_busy", 4'(e.is_busy), 4'(d[0])),
             diff("program_now", 4'(e.program_now), 4'(d[3:1])),
             diff("is_locked", 4'(e.is_locked), 4'(d[4])),
             diff("disc_step_cmd", 4'(e.disc_step_cmd), 4'(d[5])),
             diff("disc_cycle_cmd", 4'(e.disc_cycle_cmd), 4'(d[6])),
             diff("disc_halt_cmd", 4'(e.disc_halt_cmd), 4'(d[7])),
             diff("colour_request_cmd", 4'(e.colour_request_cmd), 4'(d[8])),
             diff("servo_move_cmd", 4'(e.servo_move_cmd), 4'(d[9])),
             diff("held_colour", e.held_colour, d[13:10]),
             diff("led_cmd", 4'(e.led_cmd), 4'(d[15:14])),
             diff("aux_output_cmd", 4'(e.aux_output_cmd), 4'(d[17:16])),
             diff("display_msg", e.display_msg, d[21:18])};
      if (bad != "") report($sformatf("result %0d:%s", results_seen, bad));
    endfunction
  endclass

  // Clock, reset and all block inputs start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = sps_pkg::ACT_TICK;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = sps_pkg::CFG_ACTION_WAIT;
  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  sorter_step_tracker_t tracker = new();

  // Shared stimulus controls: steady turns off idling on both sides, hold_req asks the
  // receiver for one long hold-off, ms_now is the millisecond clock that ticks carry.
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  logic [31:0] ms_now = '0;
  int          items_sent = 0;

  sorter_program_sequencer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sps_pkg::item_t mk(logic [1:0] act, logic [2:0] prg, logic [31:0] now,
                                        logic sbusy, logic nbusy, logic rst_led,
                                        logic [3:0] col);
    sps_pkg::item_t it;
    it.action          = act;
    it.program_request = prg;
    it.now_ms          = now;
    it.stepper_busy    = sbusy;
    it.sensor_busy     = nbusy;
    it.led_rested      = rst_led;
    it.colour_in       = col;
    return it;
  endfunction

  // One random item of a running program. Most are ticks with the clock moved on by up
  // to stride milliseconds; a few are stop requests, a few are noise of any action, and
  // now and then the clock jumps anywhere, which also makes every time bit toggle.
  function automatic sps_pkg::item_t next_item(int unsigned stride);
    int unsigned roll;
    logic [1:0]  act;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 32) == 0) ms_now = $urandom();
    else ms_now = ms_now + $urandom_range(0, stride);
    if (roll < 8) act = sps_pkg::ACT_STOP;
    else if (roll < 12) act = 2'($urandom_range(0, 3));
    else act = sps_pkg::ACT_TICK;
    return mk(act, 3'($urandom_range(0, 7)), ms_now, $urandom_range(0, 3) == 0,
              $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0,
              4'($urandom_range(0, 15)));
  endfunction

  // Offers one item and waits for its transfer. Valid is only lowered when an idle gap
  // is inserted, so it never drops and rises within one time step.
  task automatic offer(sps_pkg::item_t it);
    if (!steady && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= IN_W'({it.colour_in, it.led_rested, it.sensor_busy,
                        it.stepper_busy, it.now_ms, it.program_request});
    do @(posedge clk); while (!in_tready);
    tracker.note_input(it);
    items_sent++;
  endtask

  // Stops offering and waits until every expected result has come back. Each item
  // yields a result, so an empty queue means the block is idle; a few spare cycles
  // follow anyway before registers are touched.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers plus the unused index, one write per cycle.
  task automatic load_config(logic [15:0] aw, logic [15:0] sw, logic [15:0] se);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    cfg_we <= 1'b1;
    cfg_index <= sps_pkg::CFG_ACTION_WAIT; cfg_wdata <= aw;   @(posedge clk);
    cfg_index <= sps_pkg::CFG_SPLASH_WAIT; cfg_wdata <= sw;   @(posedge clk);
    cfg_index <= sps_pkg::CFG_STARTUP_END; cfg_wdata <= se;   @(posedge clk);
    cfg_index <= CFG_UNUSED;               cfg_wdata <= junk; @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(sps_pkg::CFG_ACTION_WAIT, aw);
    tracker.write_reg(sps_pkg::CFG_SPLASH_WAIT, sw);
    tracker.write_reg(sps_pkg::CFG_STARTUP_END, se);
    tracker.write_reg(CFG_UNUSED, junk);
  endtask

  // One well-formed run: occasionally re-initialize, request a program (mostly a real
  // one), then feed ticks until the program returns to rest or the run gets too long.
  // Auto and cycling only end through a stop, which next_item supplies now and then.
  task automatic run_program(int unsigned stride);
    logic [2:0] pick;
    int         n;
    pick = ($urandom_range(0, 9) == 0)
           ? 3'($urandom_range(0, 7))
           : 3'($urandom_range(sps_pkg::PRG_STEPPER, sps_pkg::PRG_STARTUP));
    if ($urandom_range(0, 29) == 0)
      offer(mk(sps_pkg::ACT_INIT, pick, ms_now, 1'b0, 1'b0, 1'b1, 4'd0));
    offer(mk(sps_pkg::ACT_START, pick, ms_now, 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             4'($urandom_range(0, 15))));
    n = 0;
    while (tracker.prog != sps_pkg::PRG_REST && n < 80) begin
      offer(next_item(stride));
      n++;
    end
  endtask

  // Result side: every transfer is checked against the oldest expectation. Ready is
  // mostly random, always high while steady is set, and held low for one long stretch
  // on request so that both internal registers fill and the input channel stalls.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet, tracker.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Main sequence: reset, a directed pass with the reset register values, then four
  // random phases with different register settings, the extremes among them.
  initial begin
    logic [15:0] aw, sw, se, widest;
    int unsigned stride;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Before initialize every action is ignored; all data bits high here.
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_STARTUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 4'hF));
    offer(mk(sps_pkg::ACT_START, sps_pkg::PRG_AUTO, 32'd0, 1'b0, 1'b0, 1'b0, 4'h0));
    offer(mk(sps_pkg::ACT_STOP, sps_pkg::PRG_REST, 32'd0, 1'b0, 1'b0, 1'b0, 4'h0));
    // Initialize, then a second initialize that must change nothing.
    offer(mk(sps_pkg::ACT_INIT, sps_pkg::PRG_REST, 32'd0, 1'b0, 1'b0, 1'b0, 4'h0));
    offer(mk(sps_pkg::ACT_INIT, sps_pkg::PRG_CYCLE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 4'hF));
    // The startup program runs first; it begins just before the time wraps, and a
    // stop while it is locked is refused. Both waits are hit one short and exactly.
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SPLASH_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_STOP, sps_pkg::PRG_REST, SPLASH_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SPLASH_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SPLASH_T0 + 32'd2999,
             1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SPLASH_T0 + 32'd3000,
             1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SPLASH_T0 + 32'd3000,
             1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SPLASH_T0 + 32'd5999,
             1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SPLASH_T0 + 32'd6000,
             1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SPLASH_T0 + 32'd6000,
             1'b0, 1'b0, 1'b1, 4'h0));
    // At rest: starting program rest keeps it at rest, and a stop is ignored.
    offer(mk(sps_pkg::ACT_START, sps_pkg::PRG_REST, SENSOR_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_STOP, sps_pkg::PRG_REST, SENSOR_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    // Manual sensor program, with the sensor busy for one tick in between.
    offer(mk(sps_pkg::ACT_START, sps_pkg::PRG_SENSOR, SENSOR_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SENSOR_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SENSOR_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SENSOR_T0, 1'b0, 1'b1, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SENSOR_T0, 1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SENSOR_T0, 1'b0, 1'b0, 1'b1, 4'hA));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SENSOR_T0 + 32'd1000,
             1'b0, 1'b0, 1'b1, 4'h0));
    offer(mk(sps_pkg::ACT_TICK, sps_pkg::PRG_REST, SENSOR_T0 + 32'd1000,
             1'b0, 1'b0, 1'b1, 4'h0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          aw = 16'($urandom_range(0, 300));
          sw = 16'($urandom_range(0, 300));
          se = 16'($urandom_range(0, 300));
        end
        1: begin aw = '0; sw = '0; se = '0; end
        2: begin aw = '1; sw = '1; se = '1; end
        default: begin
          aw = 16'($urandom_range(0, 65535));
          sw = 16'($urandom_range(0, 65535));
          se = 16'($urandom_range(0, 65535));
        end
      endcase
      drain();
      load_config(aw, sw, se);
      // Time steps scale with the longest wait so that every wait ends within a few
      // ticks; each phase starts close to the wrap of the millisecond clock.
      widest = (aw > sw) ? aw : sw;
      widest = (widest > se) ? widest : se;
      stride = widest / 3 + 2;
      ms_now = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      steady = (ph == 1);
      if (ph == 0) hold_req = 1'b1;
      while (items_sent < 25 + (ph + 1) * 150) run_program(stride);
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
